// File: design/smadf_pkg.sv
// Shared types and constants for the sync-marker audio deframer.
// Holds the controller state, parse mode, register indexes and the
// command and status bundles between controller and datapath.
package smadf_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned SKIP_W   = 6;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned WORD_W   = 64;

    localparam logic [31:0] SYNC_WORD_RESET   = 32'h032C_8088;
    localparam logic [5:0]  HEADER_SKIP_RESET = 6'd10;

    // Register index as decoded from paddr[2].
    localparam logic CFG_IDX_SYNC_WORD   = 1'b0;
    localparam logic CFG_IDX_HEADER_SKIP = 1'b1;

    typedef enum logic [1:0] {
        MODE_SEARCH  = 2'd0,
        MODE_HEADER  = 2'd1,
        MODE_PAYLOAD = 2'd2
    } mode_t;

    typedef enum logic {
        ST_RUN   = 1'b0,
        ST_DRAIN = 1'b1
    } ctrl_state_t;

    typedef struct packed {
        logic step;
        logic rd_issue;
        logic rd_load;
    } dp_cmd_t;

    typedef struct packed {
        logic step_emit;
        logic chunk_full;
        logic rd_at_end;
        logic rd_last;
    } dp_status_t;

endpackage

// File: design/smadf_ctrl.sv
// Controller of the deframer: stream handshakes, output valid and the
// gap chunk drain sequence. Depends on smadf_pkg for the command and status types.
module smadf_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output smadf_pkg::dp_cmd_t     cmd,
    input  smadf_pkg::dp_status_t  sts
);
    import smadf_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        rd_valid_reg, rd_valid_next;
    logic        reads_left_reg, reads_left_next;
    logic        out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_RUN;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
            reads_left_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            rd_valid_reg   <= rd_valid_next;
            reads_left_reg <= reads_left_next;
        end
    end

    always_comb begin
        out_free        = !out_valid_reg || m_tready;
        state_next      = state_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        out_valid_next  = out_valid_reg && !m_tready;
        rd_valid_next   = rd_valid_reg;
        reads_left_next = reads_left_reg;
        unique case (state_reg)
            ST_RUN: begin
                s_tready = out_free;
                cmd.step = s_tvalid && out_free;
                if (cmd.step && sts.step_emit) begin
                    out_valid_next = 1'b1;
                end
                if (cmd.step && sts.chunk_full) begin
                    state_next      = ST_DRAIN;
                    reads_left_next = 1'b1;
                end
            end
            ST_DRAIN: begin
                cmd.rd_load  = rd_valid_reg && out_free;
                cmd.rd_issue = reads_left_reg && (!rd_valid_reg || cmd.rd_load);
                if (cmd.rd_load) begin
                    out_valid_next = 1'b1;
                end
                rd_valid_next = cmd.rd_issue || (rd_valid_reg && !cmd.rd_load);
                if (cmd.rd_issue && sts.rd_at_end) begin
                    reads_left_next = 1'b0;
                end
                if (cmd.rd_load && sts.rd_last) begin
                    state_next = ST_RUN;
                end
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_drain_starts_with_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == ST_DRAIN) |-> reads_left_reg)
        else $error("drain entered without pending reads");
    a_run_has_no_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (!rd_valid_reg && !reads_left_reg))
        else $error("gap read outstanding outside the drain");
    a_drain_not_stuck: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> (reads_left_reg || rd_valid_reg))
        else $error("drain has nothing left but did not finish");
`endif

endmodule

// File: design/smadf_datapath.sv
// Datapath of the deframer: match window, parse mode, byte counter, word
// assembly, gap word memory and output register. Depends on smadf_pkg.
module smadf_datapath #(
    parameter int unsigned FRAME_BYTES = 160
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  smadf_pkg::dp_cmd_t            cmd,
    output smadf_pkg::dp_status_t         sts,
    input  logic [smadf_pkg::BYTE_W-1:0]  data_byte,
    input  logic [31:0]                   sync_word,
    input  logic [smadf_pkg::SKIP_W-1:0]  header_skip,
    output logic [smadf_pkg::WORD_W-1:0]  payload_word,
    output logic                          word_last,
    output logic                          from_gap
);
    import smadf_pkg::*;

    localparam int unsigned CB = $clog2(FRAME_BYTES + 1);
    localparam int unsigned CW = (CB > SKIP_W) ? CB : SKIP_W;
    localparam int unsigned NW = (FRAME_BYTES + 7) / 8;
    localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;

    mode_t                mode_reg, mode_next;
    logic [31:0]          window_reg, window_next;
    logic [2:0]           fill_reg, fill_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [WORD_W-1:0]    asm_reg, asm_next;
    logic [AW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [WORD_W-1:0]    rd_data_reg;
    logic                 rd_last_reg;
    logic [WORD_W-1:0]    out_word_reg;
    logic                 out_last_reg;
    logic                 out_gap_reg;
    logic [WORD_W-1:0]    gap_mem [NW];

    logic [2:0]           lane;
    logic [CW-1:0]        count_inc;
    logic [BYTE_W-1:0]    asm_byte;
    logic [WORD_W-1:0]    asm_word;
    logic                 word_end;
    logic                 at_frame_end;
    logic                 fill_full;
    logic [31:0]          shifted_window;
    logic [2:0]           fill_step;
    logic                 marker;
    logic                 gap_wr;
    logic [AW-1:0]        wr_addr;

    always_comb begin
        lane           = count_reg[2:0];
        count_inc      = count_reg + CW'(1);
        at_frame_end   = (count_inc == CW'(FRAME_BYTES));
        word_end       = (lane == 3'd7) || at_frame_end;
        fill_full      = fill_reg[2];
        asm_byte       = (mode_reg == MODE_PAYLOAD) ? data_byte : window_reg[31:24];
        asm_word       = ((lane == 3'd0) ? '0 : asm_reg)
                         | (WORD_W'(asm_byte) << {lane, 3'b000});
        shifted_window = {window_reg[23:0], data_byte};
        fill_step      = fill_full ? fill_reg : fill_reg + 3'd1;
        marker         = fill_step[2] && (shifted_window == sync_word);
        wr_addr        = AW'(count_reg >> 3);
        gap_wr         = 1'b0;

        mode_next   = mode_reg;
        window_next = window_reg;
        fill_next   = fill_reg;
        count_next  = count_reg;
        asm_next    = asm_reg;

        if (cmd.step) begin
            unique case (mode_reg)
                MODE_HEADER: begin
                    count_next = count_inc;
                    if (count_inc >= CW'(header_skip)) begin
                        mode_next  = MODE_PAYLOAD;
                        count_next = '0;
                    end
                end
                MODE_PAYLOAD: begin
                    asm_next   = asm_word;
                    count_next = count_inc;
                    if (at_frame_end) begin
                        mode_next   = MODE_SEARCH;
                        count_next  = '0;
                        window_next = '0;
                        fill_next   = '0;
                    end
                end
                default: begin
                    if (fill_full) begin
                        asm_next   = asm_word;
                        gap_wr     = word_end;
                        count_next = at_frame_end ? '0 : count_inc;
                    end
                    window_next = shifted_window;
                    fill_next   = fill_step;
                    mode_next   = MODE_SEARCH;
                    if (marker) begin
                        count_next  = '0;
                        window_next = '0;
                        fill_next   = '0;
                        mode_next   = (header_skip == '0) ? MODE_PAYLOAD : MODE_HEADER;
                    end
                end
            endcase
        end

        rd_ptr_next = rd_ptr_reg;
        if (cmd.rd_issue) begin
            rd_ptr_next = sts.rd_at_end ? '0 : rd_ptr_reg + AW'(1);
        end
    end

    always_comb begin
        sts.step_emit  = (mode_reg == MODE_PAYLOAD) && word_end;
        sts.chunk_full = (mode_reg != MODE_HEADER) && (mode_reg != MODE_PAYLOAD)
                         && fill_full && at_frame_end;
        sts.rd_at_end  = (rd_ptr_reg == AW'(NW - 1));
        sts.rd_last    = rd_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_SEARCH;
            window_reg <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
            rd_ptr_reg <= '0;
        end else begin
            mode_reg   <= mode_next;
            window_reg <= window_next;
            fill_reg   <= fill_next;
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        asm_reg <= asm_next;
        if (cmd.step && (mode_reg == MODE_PAYLOAD) && word_end) begin
            out_word_reg <= asm_word;
            out_last_reg <= at_frame_end;
            out_gap_reg  <= 1'b0;
        end else if (cmd.rd_load) begin
            out_word_reg <= rd_data_reg;
            out_last_reg <= rd_last_reg;
            out_gap_reg  <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.step && gap_wr) begin
            gap_mem[wr_addr] <= asm_word;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= gap_mem[rd_ptr_reg];
            rd_last_reg <= sts.rd_at_end;
        end
    end

    assign payload_word = out_word_reg;
    assign word_last    = out_last_reg;
    assign from_gap     = out_gap_reg;

endmodule

// File: design/sync_marker_audio_deframer_core.sv
// Top level of the sync-marker audio deframer: configuration registers,
// controller and datapath. Depends on smadf_pkg, smadf_ctrl and smadf_datapath.
//
// The block takes at most one byte per cycle and hunts for the four-byte sync word.
// After a marker it skips header_skip bytes and then sends FRAME_BYTES payload
// bytes as 64-bit words (earliest byte lowest), one word in the output
// register every eighth byte, with tlast on the final word. Bytes pushed out
// of the match window while hunting are packed into a gap word memory of
// ceil(FRAME_BYTES/8) words; when FRAME_BYTES of them are stored, input
// stops while the chunk is read from that memory, one word per cycle while
// the output register is empty or being taken, and sent with tuser set.
// Otherwise a byte is taken in every cycle in which the output register is
// empty or being taken. A shorter gap remainder is dropped at the next
// marker. No clearing pass follows reset.
module sync_marker_audio_deframer_core #(
    parameter int unsigned FRAME_BYTES = 160
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,  // [7:0] data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [63:0]                    m_tdata,  // [63:0] payload_word
    output logic                           m_tlast,  // word_last
    output logic                           m_tuser,  // [0] from_gap
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [smadf_pkg::ADDR_W-1:0]   paddr,
    input  logic [smadf_pkg::DATA_W-1:0]   pwdata,
    output logic [smadf_pkg::DATA_W-1:0]   prdata,
    output logic                           pready
);
    import smadf_pkg::*;

    logic [31:0]       sync_word_reg;
    logic [SKIP_W-1:0] header_skip_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_status_t        sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_word_reg   <= SYNC_WORD_RESET;
            header_skip_reg <= HEADER_SKIP_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == CFG_IDX_SYNC_WORD) begin
                sync_word_reg <= pwdata;
            end else begin
                header_skip_reg <= pwdata[SKIP_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == CFG_IDX_HEADER_SKIP) begin
            prdata = DATA_W'(header_skip_reg);
        end else begin
            prdata = sync_word_reg;
        end
    end

    smadf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    smadf_datapath #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .sts          (sts),
        .data_byte    (s_tdata),
        .sync_word    (sync_word_reg),
        .header_skip  (header_skip_reg),
        .payload_word (m_tdata),
        .word_last    (m_tlast),
        .from_gap     (m_tuser)
    );

endmodule

// File: test/sync_marker_audio_deframer_core_test.sv
// Testbench for sync_marker_audio_deframer_core: drives byte streams and register
// writes, predicts every output word and compares them in order.
// Depends on smadf_pkg and the sync_marker_audio_deframer_core RTL.
module sync_marker_audio_deframer_core_test;
    import smadf_pkg::*;

    localparam int unsigned FRAME = 160;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic [63:0] word;
        logic        last;
        logic        gap;
    } audio_word_t;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata = 8'd0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [63:0]         m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Shadow copy of the registers and of the deframer state.
    logic [31:0]         sync_cfg = SYNC_WORD_RESET;
    logic [5:0]          skip_cfg = HEADER_SKIP_RESET;
    logic [31:0]         hunt_window = '0;
    int unsigned         hunt_fill = 0;
    mode_t               parse_state = MODE_SEARCH;
    int unsigned         byte_pos = 0;
    logic [63:0]         word_acc = '0;
    logic [7:0]          gap_bytes [FRAME];
    int unsigned         gap_fill = 0;

    logic [7:0]          bytes_to_send [$];
    audio_word_t         words_due [$];
    int unsigned         err_count = 0;
    int unsigned         cycles = 0;
    logic                calm = 1'b0;
    logic                hold_req = 1'b0;
    logic                hold_done = 1'b0;
    int unsigned         hold_left = 0;
    audio_word_t         due_word;

    sync_marker_audio_deframer_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] data_byte
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [63:0] payload_word
        .m_tlast  (m_tlast),   // word_last
        .m_tuser  (m_tuser),   // [0] from_gap
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    task automatic queue_word(input logic [63:0] word, input logic last, input logic gap);
        audio_word_t w;
        w.word = word;
        w.last = last;
        w.gap  = gap;
        words_due.push_back(w);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        logic [63:0] w;
        if (parse_state == MODE_HEADER) begin
            byte_pos = byte_pos + 1;
            if (byte_pos >= skip_cfg) begin
                parse_state = MODE_PAYLOAD;
                byte_pos = 0;
            end
        end else if (parse_state == MODE_PAYLOAD) begin
            word_acc = word_acc | (64'(b) << (8 * (byte_pos % 8)));
            if (byte_pos % 8 == 7 || byte_pos + 1 >= FRAME) begin
                queue_word(word_acc, byte_pos + 1 >= FRAME, 1'b0);
                word_acc = '0;
            end
            if (byte_pos + 1 >= FRAME) begin
                parse_state = MODE_SEARCH;
                byte_pos = 0;
                hunt_window = '0;
                hunt_fill = 0;
            end else begin
                byte_pos = byte_pos + 1;
            end
        end else begin
            if (hunt_fill >= 4) begin
                if (gap_fill < FRAME) begin
                    gap_bytes[gap_fill] = hunt_window[31:24];
                    gap_fill = gap_fill + 1;
                end
                if (gap_fill >= FRAME) begin
                    w = '0;
                    for (int i = 0; i < FRAME; i++) begin
                        w = w | (64'(gap_bytes[i]) << (8 * (i % 8)));
                        if (i % 8 == 7 || i + 1 == FRAME) begin
                            queue_word(w, i + 1 == FRAME, 1'b1);
                            w = '0;
                        end
                    end
                    gap_fill = 0;
                end
            end else begin
                hunt_fill = hunt_fill + 1;
            end
            hunt_window = {hunt_window[23:0], b};
            if (hunt_fill >= 4 && hunt_window == sync_cfg) begin
                gap_fill = 0;
                hunt_window = '0;
                hunt_fill = 0;
                byte_pos = 0;
                word_acc = '0;
                parse_state = (skip_cfg == 0) ? MODE_PAYLOAD : MODE_HEADER;
            end else begin
                parse_state = MODE_SEARCH;
            end
        end
    endtask

    task automatic flag_error(input string what, input logic [63:0] got,
                              input logic [63:0] want);
        $display("ERROR: %s got %h expected %h", what, got, want);
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                deframe_byte(s_tdata);
            end
            if (bytes_to_send.size() > 0 && (calm || $urandom_range(0, 99) >= 35)) begin
                s_tvalid <= 1'b1;
                s_tdata <= bytes_to_send.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (words_due.size() == 0) begin
                    flag_error("word with none due", m_tdata, '0);
                end else begin
                    due_word = words_due.pop_front();
                    if (m_tdata !== due_word.word)
                        flag_error("payload_word", m_tdata, due_word.word);
                    if (m_tlast !== due_word.last)
                        flag_error("word_last", 64'(m_tlast), 64'(due_word.last));
                    if (m_tuser !== due_word.gap)
                        flag_error("from_gap", 64'(m_tuser), 64'(due_word.gap));
                end
            end
            if (hold_req && !hold_done) begin
                hold_left = 400;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= calm || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == CFG_IDX_SYNC_WORD)
            sync_cfg = value;
        else
            skip_cfg = value[5:0];
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (bytes_to_send.size() != 0 || s_tvalid || words_due.size() != 0)
            @(negedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic push_byte(input logic [7:0] b);
        bytes_to_send.push_back(b);
    endtask

    task automatic push_part(input int len);
        for (int k = 0; k < len; k++)
            push_byte(sync_cfg[31 - 8 * k -: 8]);
    endtask

    task automatic push_payload(input int n);
        int at;
        at = (n >= 4 && $urandom_range(0, 1) == 1) ? $urandom_range(0, n - 4) : -1;
        for (int i = 0; i < n; i++) begin
            if (at >= 0 && i >= at && i < at + 4)
                push_byte(sync_cfg[31 - 8 * (i - at) -: 8]);
            else
                push_byte(8'($urandom));
        end
    endtask

    // Random bytes with the odd broken marker: a true prefix, then a wrong byte.
    task automatic push_noise(input int n);
        int i;
        int len;
        i = 0;
        while (i < n) begin
            if ($urandom_range(0, 15) == 0) begin
                len = $urandom_range(1, 3);
                push_part(len);
                push_byte(sync_cfg[31 - 8 * len -: 8] ^ 8'($urandom_range(1, 255)));
                i = i + len + 1;
            end else begin
                push_byte(8'($urandom));
                i = i + 1;
            end
        end
    endtask

    task automatic push_frame();
        push_part(4);
        push_payload(skip_cfg);
        push_payload(FRAME);
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_byte(8'h00);
        push_byte(8'hFF);
        push_part(3);
        push_byte(8'h00);
        push_byte(SYNC_WORD_RESET[31:24]);
        push_part(4);
        push_part(4);
        push_payload(HEADER_SKIP_RESET - 4);

        hold_req = 1'b1;
        push_payload(FRAME - 3);
        push_part(3);
        push_byte(SYNC_WORD_RESET[7:0]);
        push_noise(3);
        wait_drained();

        calm = 1'b1;
        write_reg(CFG_IDX_SYNC_WORD, 32'hFFFF_FFFF);
        write_reg(CFG_IDX_HEADER_SKIP, 32'd0);
        push_noise(164);
        push_frame();
        wait_drained();
        calm = 1'b0;

        if (err_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
